// ===== rtl/omw_pkg.sv =====
`default_nettype none

package omw_pkg;

	localparam int WHEEL_COUNT     = 4;
	localparam int DUTY_FULL_SCALE = 255;

	localparam int ANGLE_W   = 9;
	localparam int SPEED_W   = 8;
	localparam int CORR_W    = 9;
	localparam int DUTY_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int QCOS_W    = 15;
	localparam int COS_W     = QCOS_W + 1;
	localparam int FRAC_W    = 15;
	localparam int VAL_W     = 25;
	localparam int MAG_W     = VAL_W - 1;
	localparam int TWICE_FS  = 2 * DUTY_FULL_SCALE;
	localparam int NUM_W     = MAG_W + $clog2(TWICE_FS + 1);
	localparam int DEN_W     = MAG_W + 1;
	localparam int QUOT_W    = $clog2(DUTY_FULL_SCALE + 1);

	localparam int FRONT_STAGES = 2;
	localparam int MIX_STAGES   = 5;
	localparam int LATENCY      = FRONT_STAGES + MIX_STAGES + QUOT_W + 1;

	localparam int QUARTER   = 90;
	localparam int TABLE_LEN = QUARTER + 1;
	localparam int IDX_W     = $clog2(TABLE_LEN);

	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [MAG_W-1:0] ROUND_HALF = MAG_W'(1) << (FRAC_W - 1);
	localparam logic [MAG_W-1:0] SCALE_LIMIT = MAG_W'(DUTY_FULL_SCALE) << FRAC_W;

	typedef logic [ANGLE_W-1:0]       angle_t;
	typedef logic [SPEED_W-1:0]       speed_t;
	typedef logic signed [CORR_W-1:0] corr_t;
	typedef logic signed [COS_W-1:0]  cos_t;
	typedef logic signed [VAL_W-1:0]  val_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef logic [NUM_W-1:0]         num_t;
	typedef logic [DEN_W-1:0]         den_t;
	typedef logic [QUOT_W-1:0]        quot_t;
	typedef logic [DUTY_W-1:0]        duty_t;
	typedef logic [WHEEL_COUNT-1:0]   mask_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
	typedef logic [IDX_W-1:0]         tab_idx_t;
	typedef logic [QCOS_W-1:0]        qcos_t;
	typedef qcos_t                    cos_table_t [TABLE_LEN];

	typedef struct packed {
		logic  valid;
		logic  scale;
		mask_t line_a;
		mask_t line_b;
	} flags_t;

	// First-quadrant cosine in unsigned Q0.15 from a Q30 Taylor series of eleven terms.
	function automatic cos_table_t build_cos_table();
		cos_table_t         tab;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        q;
		logic signed [63:0] sum;
		for (int d = 0; d <= QUARTER; d++) begin
			x = (64'(d) * PI_Q30) / 64'd180;
			x2 = (x * x) >> 30;
			term = 64'd1 << 30;
			sum = $signed(term);
			for (int k = 1; k <= 10; k++) begin
				term = (term * x2) >> 30;
				term = term / 64'((2 * k - 1) * (2 * k));
				if ((k % 2) != 0) begin
					sum = sum - $signed(term);
				end else begin
					sum = sum + $signed(term);
				end
			end
			if (sum < 0) begin
				sum = 64'sd0;
			end
			q = ($unsigned(sum) + (64'd1 << 14)) >> 15;
			if (q > 64'd32767) begin
				q = 64'd32767;
			end
			tab[d] = QCOS_W'(q);
		end
		return tab;
	endfunction

	localparam cos_table_t COS_TABLE = build_cos_table();

endpackage

`default_nettype wire

// ===== rtl/omni_wheel_drive_mixer.sv =====
// Four-wheel omni drive mixer. A command transfers at a rising edge with start high; busy
// is always low, so a new command may be given in every cycle. Its result appears on
// duty0..duty3 and the two direction masks, for one cycle with done high, and there is no
// way to hold it. On its way a command passes through two stages of angle reduction
// and cosine lookup, five stages of multiply, magnitude and maximum search, the eight-stage
// restoring divider that scales the wheels when the largest one exceeds full scale, and one
// output register. Mounting angles are written through wr_en, wr_index and wr_data and apply
// to commands that transfer after the write; indexes above three are ignored.

`default_nettype none

module omni_wheel_drive_mixer (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	output logic                      busy,
	input  omw_pkg::speed_t           travel_speed,
	input  omw_pkg::angle_t           heading,
	input  omw_pkg::corr_t            spin_correction,
	input  wire                       wr_en,
	input  omw_pkg::cfg_idx_t         wr_index,
	input  omw_pkg::angle_t           wr_data,
	output logic                      done,
	output omw_pkg::duty_t            duty0,
	output omw_pkg::duty_t            duty1,
	output omw_pkg::duty_t            duty2,
	output omw_pkg::duty_t            duty3,
	output omw_pkg::mask_t            line_a_mask,
	output omw_pkg::mask_t            line_b_mask
);

	omw_pkg::angle_t angle_q [omw_pkg::WHEEL_COUNT];
	logic            accept;

	logic            valid_s2;
	omw_pkg::speed_t speed_s2;
	omw_pkg::corr_t  corr_s2;
	omw_pkg::cos_t   cos_s2 [omw_pkg::WHEEL_COUNT];

	omw_pkg::flags_t flags_s7;
	omw_pkg::num_t   num_s7 [omw_pkg::WHEEL_COUNT];
	omw_pkg::den_t   den_s7;
	omw_pkg::duty_t  rduty_s7 [omw_pkg::WHEEL_COUNT];
	omw_pkg::duty_t  duty [omw_pkg::WHEEL_COUNT];

	assign busy = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q[0] <= omw_pkg::ANGLE_W'(45);
			angle_q[1] <= omw_pkg::ANGLE_W'(135);
			angle_q[2] <= omw_pkg::ANGLE_W'(225);
			angle_q[3] <= omw_pkg::ANGLE_W'(315);
		end else if (wr_en) begin
			for (int i = 0; i < omw_pkg::WHEEL_COUNT; i++) begin
				if (wr_index == omw_pkg::CFG_IDX_W'(i)) begin
					angle_q[i] <= wr_data;
				end
			end
		end
	end

	omw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.speed    (travel_speed),
		.heading  (heading),
		.corr     (spin_correction),
		.angle    (angle_q),
		.valid_s2 (valid_s2),
		.speed_s2 (speed_s2),
		.corr_s2  (corr_s2),
		.cos_s2   (cos_s2)
	);

	omw_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (valid_s2),
		.speed    (speed_s2),
		.corr     (corr_s2),
		.cos_in   (cos_s2),
		.flags_s7 (flags_s7),
		.num_s7   (num_s7),
		.den_s7   (den_s7),
		.rduty_s7 (rduty_s7)
	);

	omw_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.flags_in    (flags_s7),
		.num_in      (num_s7),
		.den_in      (den_s7),
		.rduty_in    (rduty_s7),
		.done        (done),
		.duty        (duty),
		.line_a_mask (line_a_mask),
		.line_b_mask (line_b_mask)
	);

	assign duty0 = duty[0];
	assign duty1 = duty[1];
	assign duty2 = duty[2];
	assign duty3 = duty[3];

	// Every result traces back to an earlier command transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, omw_pkg::LATENCY))
	else $error("result without a matching command transfer");

	// Each wheel has at least one direction line set.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((line_a_mask | line_b_mask) == '1))
	else $error("wheel with no direction line set");

	// Wheel 0, when its value is exactly zero, must have zero duty.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && line_a_mask[0] && line_b_mask[0]) |-> (duty0 == '0))
	else $error("zero wheel value with nonzero duty");

endmodule

`default_nettype wire

// ===== rtl/omw_front.sv =====
`default_nettype none

module omw_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  accept,
	input  omw_pkg::speed_t      speed,
	input  omw_pkg::angle_t      heading,
	input  omw_pkg::corr_t       corr,
	input  omw_pkg::angle_t      angle [omw_pkg::WHEEL_COUNT],
	output logic                 valid_s2,
	output omw_pkg::speed_t      speed_s2,
	output omw_pkg::corr_t       corr_s2,
	output omw_pkg::cos_t        cos_s2 [omw_pkg::WHEEL_COUNT]
);

	localparam logic [omw_pkg::ANGLE_W:0] FULL_TURN = (omw_pkg::ANGLE_W + 1)'(360);
	localparam logic [omw_pkg::ANGLE_W:0] TWO_TURNS = (omw_pkg::ANGLE_W + 1)'(720);
	localparam omw_pkg::angle_t DEG_90  = omw_pkg::ANGLE_W'(90);
	localparam omw_pkg::angle_t DEG_180 = omw_pkg::ANGLE_W'(180);
	localparam omw_pkg::angle_t DEG_270 = omw_pkg::ANGLE_W'(270);
	localparam omw_pkg::angle_t DEG_360 = omw_pkg::ANGLE_W'(360);

	logic            valid_s1;
	omw_pkg::speed_t speed_s1;
	omw_pkg::corr_t  corr_s1;
	omw_pkg::angle_t ang_s1 [omw_pkg::WHEEL_COUNT];
	omw_pkg::angle_t ang_red [omw_pkg::WHEEL_COUNT];
	omw_pkg::cos_t   cos_val [omw_pkg::WHEEL_COUNT];

	always_comb begin
		for (int i = 0; i < omw_pkg::WHEEL_COUNT; i++) begin
			logic [omw_pkg::ANGLE_W:0] sum;
			sum = {1'b0, heading} + {1'b0, angle[i]};
			if (sum >= TWO_TURNS) begin
				sum = sum - TWO_TURNS;
			end else if (sum >= FULL_TURN) begin
				sum = sum - FULL_TURN;
			end
			ang_red[i] = sum[omw_pkg::ANGLE_W-1:0];
		end
	end

	always_comb begin
		for (int i = 0; i < omw_pkg::WHEEL_COUNT; i++) begin
			omw_pkg::angle_t  folded;
			logic             neg;
			omw_pkg::cos_t    mag;
			if (ang_s1[i] <= DEG_90) begin
				folded = ang_s1[i];
				neg = 1'b0;
			end else if (ang_s1[i] <= DEG_180) begin
				folded = DEG_180 - ang_s1[i];
				neg = 1'b1;
			end else if (ang_s1[i] <= DEG_270) begin
				folded = ang_s1[i] - DEG_180;
				neg = 1'b1;
			end else begin
				folded = DEG_360 - ang_s1[i];
				neg = 1'b0;
			end
			mag = $signed({1'b0, omw_pkg::COS_TABLE[folded[omw_pkg::IDX_W-1:0]]});
			cos_val[i] = neg ? -mag : mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		speed_s1 <= speed;
		corr_s1 <= corr;
		ang_s1 <= ang_red;
		speed_s2 <= speed_s1;
		corr_s2 <= corr_s1;
		cos_s2 <= cos_val;
	end

endmodule

`default_nettype wire

// ===== rtl/omw_mix.sv =====
`default_nettype none

module omw_mix (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  valid_in,
	input  omw_pkg::speed_t      speed,
	input  omw_pkg::corr_t       corr,
	input  omw_pkg::cos_t        cos_in [omw_pkg::WHEEL_COUNT],
	output omw_pkg::flags_t      flags_s7,
	output omw_pkg::num_t        num_s7 [omw_pkg::WHEEL_COUNT],
	output omw_pkg::den_t        den_s7,
	output omw_pkg::duty_t       rduty_s7 [omw_pkg::WHEEL_COUNT]
);

	logic            valid_s3;
	omw_pkg::val_t   v_s3 [omw_pkg::WHEEL_COUNT];
	omw_pkg::val_t   v_next [omw_pkg::WHEEL_COUNT];

	omw_pkg::flags_t flags_s4;
	omw_pkg::flags_t flags_s5;
	omw_pkg::flags_t flags_s6;
	omw_pkg::flags_t flags_next_s4;
	omw_pkg::mag_t   mag_s4 [omw_pkg::WHEEL_COUNT];
	omw_pkg::mag_t   mag_s5 [omw_pkg::WHEEL_COUNT];
	omw_pkg::mag_t   mag_s6 [omw_pkg::WHEEL_COUNT];
	omw_pkg::mag_t   mag_next [omw_pkg::WHEEL_COUNT];
	omw_pkg::mag_t   max01_s5;
	omw_pkg::mag_t   max23_s5;
	omw_pkg::mag_t   max_s6;

	always_comb begin
		for (int i = 0; i < omw_pkg::WHEEL_COUNT; i++) begin
			omw_pkg::val_t prod;
			prod = cos_in[i] * $signed({1'b0, speed});
			v_next[i] = prod + $signed({corr, omw_pkg::FRAC_W'(0)});
		end
	end

	always_comb begin
		flags_next_s4 = '0;
		flags_next_s4.valid = valid_s3;
		for (int i = 0; i < omw_pkg::WHEEL_COUNT; i++) begin
			omw_pkg::val_t absval;
			absval = v_s3[i][omw_pkg::VAL_W-1] ? -v_s3[i] : v_s3[i];
			mag_next[i] = absval[omw_pkg::MAG_W-1:0];
			flags_next_s4.line_a[i] = !v_s3[i][omw_pkg::VAL_W-1];
			flags_next_s4.line_b[i] = v_s3[i][omw_pkg::VAL_W-1] || (v_s3[i] == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			flags_s4 <= '0;
			flags_s5 <= '0;
			flags_s6 <= '0;
			flags_s7 <= '0;
		end else begin
			valid_s3 <= valid_in;
			flags_s4 <= flags_next_s4;
			flags_s5 <= flags_s4;
			flags_s6 <= flags_s5;
			flags_s7 <= '{valid: flags_s6.valid, scale: (max_s6 > omw_pkg::SCALE_LIMIT),
				line_a: flags_s6.line_a, line_b: flags_s6.line_b};
		end
	end

	always_ff @(posedge clk) begin
		v_s3 <= v_next;
		mag_s4 <= mag_next;
		mag_s5 <= mag_s4;
		max01_s5 <= (mag_s4[0] > mag_s4[1]) ? mag_s4[0] : mag_s4[1];
		max23_s5 <= (mag_s4[2] > mag_s4[3]) ? mag_s4[2] : mag_s4[3];
		mag_s6 <= mag_s5;
		max_s6 <= (max01_s5 > max23_s5) ? max01_s5 : max23_s5;
		den_s7 <= {max_s6, 1'b0};
		for (int i = 0; i < omw_pkg::WHEEL_COUNT; i++) begin
			num_s7[i] <= omw_pkg::NUM_W'(mag_s6[i]) * omw_pkg::NUM_W'(omw_pkg::TWICE_FS)
				+ omw_pkg::NUM_W'(max_s6);
			rduty_s7[i] <= omw_pkg::DUTY_W'((mag_s6[i] + omw_pkg::ROUND_HALF)
				>> omw_pkg::FRAC_W);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/omw_scale.sv =====
`default_nettype none

module omw_scale (
	input  wire                  clk,
	input  wire                  arst_n,
	input  omw_pkg::flags_t      flags_in,
	input  omw_pkg::num_t        num_in [omw_pkg::WHEEL_COUNT],
	input  omw_pkg::den_t        den_in,
	input  omw_pkg::duty_t       rduty_in [omw_pkg::WHEEL_COUNT],
	output logic                 done,
	output omw_pkg::duty_t       duty [omw_pkg::WHEEL_COUNT],
	output omw_pkg::mask_t       line_a_mask,
	output omw_pkg::mask_t       line_b_mask
);

	localparam int STAGES = omw_pkg::QUOT_W;

	omw_pkg::flags_t flags_s [STAGES];
	omw_pkg::den_t   den_s [STAGES];
	omw_pkg::num_t   rem_s [STAGES][omw_pkg::WHEEL_COUNT];
	omw_pkg::quot_t  quot_s [STAGES][omw_pkg::WHEEL_COUNT];
	omw_pkg::duty_t  rduty_s [STAGES][omw_pkg::WHEEL_COUNT];

	for (genvar j = 0; j < STAGES; j++) begin : g_stage
		localparam int BIT = STAGES - 1 - j;

		omw_pkg::flags_t flags_prev;
		omw_pkg::den_t   den_prev;
		omw_pkg::num_t   rem_prev [omw_pkg::WHEEL_COUNT];
		omw_pkg::quot_t  quot_prev [omw_pkg::WHEEL_COUNT];
		omw_pkg::duty_t  rduty_prev [omw_pkg::WHEEL_COUNT];
		omw_pkg::num_t   rem_next [omw_pkg::WHEEL_COUNT];
		omw_pkg::quot_t  quot_next [omw_pkg::WHEEL_COUNT];

		if (j == 0) begin : g_first
			assign flags_prev = flags_in;
			assign den_prev = den_in;
			assign rem_prev = num_in;
			assign quot_prev = '{default: '0};
			assign rduty_prev = rduty_in;
		end else begin : g_rest
			assign flags_prev = flags_s[j-1];
			assign den_prev = den_s[j-1];
			assign rem_prev = rem_s[j-1];
			assign quot_prev = quot_s[j-1];
			assign rduty_prev = rduty_s[j-1];
		end

		always_comb begin
			for (int i = 0; i < omw_pkg::WHEEL_COUNT; i++) begin
				omw_pkg::num_t trial;
				trial = omw_pkg::NUM_W'(den_prev) << BIT;
				if (rem_prev[i] >= trial) begin
					rem_next[i] = rem_prev[i] - trial;
					quot_next[i] = quot_prev[i] | (omw_pkg::QUOT_W'(1) << BIT);
				end else begin
					rem_next[i] = rem_prev[i];
					quot_next[i] = quot_prev[i];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				flags_s[j] <= '0;
			end else begin
				flags_s[j] <= flags_prev;
			end
		end

		always_ff @(posedge clk) begin
			den_s[j] <= den_prev;
			rem_s[j] <= rem_next;
			quot_s[j] <= quot_next;
			rduty_s[j] <= rduty_prev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= flags_s[STAGES-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		line_a_mask <= flags_s[STAGES-1].line_a;
		line_b_mask <= flags_s[STAGES-1].line_b;
		for (int i = 0; i < omw_pkg::WHEEL_COUNT; i++) begin
			duty[i] <= flags_s[STAGES-1].scale ? omw_pkg::DUTY_W'(quot_s[STAGES-1][i])
				: rduty_s[STAGES-1][i];
		end
	end

endmodule

`default_nettype wire
